>>> design/tcce_pkg.sv
// Shared types and constants for the text console character engine.
// Used by tcce_ctrl, tcce_datapath and text_console_char_engine; no dependencies.
package tcce_pkg;

   // Function codes carried in the request
   localparam logic [1:0] FUNC_PUT   = 2'd0;
   localparam logic [1:0] FUNC_CLEAR = 2'd1;
   localparam logic [1:0] FUNC_SETPOS = 2'd2;
   localparam logic [1:0] FUNC_READ  = 2'd3;

   // Control characters and tab spacing
   localparam logic [7:0] CHAR_NEWLINE = 8'd10;
   localparam logic [7:0] CHAR_TAB     = 8'd9;
   localparam int unsigned TAB_STEP = 4;
   localparam int unsigned TAB_BITS = $clog2(TAB_STEP);

   // Colour register value after reset
   localparam logic [7:0] COLOUR_RESET = 8'h07;

   // Field widths of the request and response
   localparam int unsigned FUNC_W   = 2;
   localparam int unsigned CHAR_W   = 8;
   localparam int unsigned IN_COL_W = 7;
   localparam int unsigned IN_ROW_W = 5;
   localparam int unsigned OFFSET_W = 11;
   localparam int unsigned COLOUR_W = 8;
   // Wide enough for the cursor offset at the largest grid
   localparam int unsigned OFS_CALC_W = 12;

   // Commands from controller to datapath
   typedef struct packed {
      logic load_item;     // latch accepted request fields
      logic exec;          // perform the item's cursor update / cell write / read
      logic sweep_start;   // restart the blanking counter
      logic sweep_wr;      // write a zero cell at the sweep address
      logic sweep_all;     // sweep covers the whole grid, else one row
      logic read_capture;  // capture the memory read data
      logic rsp_load;      // load the response register
   } ctl_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic [1:0] func;
      logic       scroll_needed;
      logic       sweep_last;
   } ctl_status_type;

endpackage

>>> design/tcce_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcce_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/tcce_ctrl.sv
// Controller state machine for the text console character engine.
// Depends on tcce_pkg for the command and status structs and function codes.
module tcce_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  tcce_pkg::ctl_status_type status,
   output tcce_pkg::ctl_cmd_type    cmd
);

   localparam logic [2:0] S_INIT   = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_EXEC   = 3'd2;
   localparam logic [2:0] S_RDWAIT = 3'd3;
   localparam logic [2:0] S_SCROLL = 3'd4;
   localparam logic [2:0] S_CLEAR  = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;
   logic       accept;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) || ((state_ff == S_DONE) && out_free);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.load_item = accept;
      case (state_ff)
         S_INIT: begin
            cmd.sweep_wr  = 1'b1;
            cmd.sweep_all = 1'b1;
            if (status.sweep_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) state_in = S_EXEC;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            case (status.func)
               tcce_pkg::FUNC_PUT: begin
                  if (status.scroll_needed) begin
                     cmd.sweep_start = 1'b1;
                     state_in = S_SCROLL;
                  end else begin
                     state_in = S_DONE;
                  end
               end
               tcce_pkg::FUNC_CLEAR: begin
                  cmd.sweep_start = 1'b1;
                  state_in = S_CLEAR;
               end
               tcce_pkg::FUNC_SETPOS: state_in = S_DONE;
               tcce_pkg::FUNC_READ:   state_in = S_RDWAIT;
               default:               state_in = S_DONE;
            endcase
         end
         S_RDWAIT: begin
            cmd.read_capture = 1'b1;
            state_in = S_DONE;
         end
         S_SCROLL: begin
            cmd.sweep_wr = 1'b1;
            if (status.sweep_last) state_in = S_DONE;
         end
         S_CLEAR: begin
            cmd.sweep_wr  = 1'b1;
            cmd.sweep_all = 1'b1;
            if (status.sweep_last) state_in = S_DONE;
         end
         S_DONE: begin
            // Hand the result over and take the next transaction in the same cycle
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               state_in = accept ? S_EXEC : S_IDLE;
            end
         end
         default: state_in = S_INIT;
      endcase
   end

   // Response valid: set on load, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> design/tcce_datapath.sv
// Datapath of the text console: cursor, rotating row origin, cell memory and response.
// Depends on tcce_pkg and tcce_ram.
module tcce_datapath #(
   parameter int unsigned COLUMNS = 80,
   parameter int unsigned ROWS    = 25
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tcce_pkg::ctl_cmd_type              cmd,
   output tcce_pkg::ctl_status_type           status,
   input  logic [tcce_pkg::FUNC_W-1:0]        req_func,
   input  logic [tcce_pkg::CHAR_W-1:0]        req_ch,
   input  logic [tcce_pkg::IN_COL_W-1:0]      req_col,
   input  logic [tcce_pkg::IN_ROW_W-1:0]      req_row,
   input  logic                              csr_valid,
   input  logic [tcce_pkg::COLOUR_W-1:0]      csr_data,
   output logic [tcce_pkg::OFFSET_W-1:0]      rsp_cursor_offset,
   output logic [tcce_pkg::CHAR_W-1:0]        rsp_cell_char,
   output logic [tcce_pkg::COLOUR_W-1:0]      rsp_cell_colour
);

   localparam int unsigned CELLS = COLUMNS * ROWS;
   localparam int unsigned AW    = $clog2(CELLS);
   localparam int unsigned COL_W = $clog2(COLUMNS);
   localparam int unsigned ROW_W = $clog2(ROWS);
   localparam int unsigned CELL_W = tcce_pkg::CHAR_W + tcce_pkg::COLOUR_W;
   localparam int unsigned OW = tcce_pkg::OFS_CALC_W;

   localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
   localparam logic [AW-1:0]    COLS_A   = AW'(COLUMNS);

   // Item, cursor, origin and sweep registers
   logic [1:0]                      func_ff;
   logic [tcce_pkg::CHAR_W-1:0]     ch_ff;
   logic [COL_W-1:0]                icol_ff, icol_in;
   logic [ROW_W-1:0]                irow_ff, irow_in;
   logic [COL_W-1:0]                ccol_ff, ccol_in;
   logic [ROW_W-1:0]                crow_ff, crow_in;
   logic [ROW_W-1:0]                top_ff, top_in;
   logic [AW-1:0]                   base_ff, base_in;
   logic [AW-1:0]                   cnt_ff, cnt_in;
   logic [tcce_pkg::COLOUR_W-1:0]   colour_ff;
   logic [CELL_W-1:0]               rd_ff;
   logic [tcce_pkg::OFFSET_W-1:0]   ofs_ff;
   logic [tcce_pkg::CHAR_W-1:0]     rchar_ff;
   logic [tcce_pkg::COLOUR_W-1:0]   rcolour_ff;

   // Put-character cursor advance
   logic [COL_W:0]   tab_next;
   logic [COL_W-1:0] put_col;
   logic             put_adv;
   logic             put_write;
   logic [ROW_W-1:0] top_next;

   // Addressing
   logic [ROW_W:0]   cur_prow_sum, rd_prow_sum;
   logic [ROW_W-1:0] cur_prow, rd_prow;
   logic [AW-1:0]    cur_addr, rd_addr, sweep_addr;
   logic             ram_we;
   logic [AW-1:0]    ram_waddr;
   logic [CELL_W-1:0] ram_wdata, ram_rdata;
   logic [OW-1:0]    ofs_full;

   // Clamp request position to the grid
   assign icol_in = (req_col > tcce_pkg::IN_COL_W'(COLUMNS - 1)) ? COL_LAST
                                                                 : req_col[COL_W-1:0];
   assign irow_in = (req_row > tcce_pkg::IN_ROW_W'(ROWS - 1)) ? ROW_LAST
                                                              : req_row[ROW_W-1:0];

   // Next cursor column for a put
   assign tab_next = {1'b0, ccol_ff} + (COL_W + 1)'(tcce_pkg::TAB_STEP)
                     - (COL_W + 1)'(ccol_ff[tcce_pkg::TAB_BITS-1:0]);
   always_comb begin
      put_col   = '0;
      put_adv   = 1'b0;
      put_write = 1'b0;
      if (ch_ff == tcce_pkg::CHAR_NEWLINE) begin
         put_adv = 1'b1;
      end else if (ch_ff == tcce_pkg::CHAR_TAB) begin
         if (tab_next >= (COL_W + 1)'(COLUMNS)) begin
            put_adv = 1'b1;
         end else begin
            put_col = tab_next[COL_W-1:0];
         end
      end else begin
         put_write = 1'b1;
         if (ccol_ff == COL_LAST) begin
            put_adv = 1'b1;
         end else begin
            put_col = ccol_ff + COL_W'(1);
         end
      end
   end

   assign top_next = (top_ff == ROW_LAST) ? '0 : top_ff + ROW_W'(1);

   // Status back to the controller
   assign status.func          = func_ff;
   assign status.scroll_needed = put_adv && (crow_ff == ROW_LAST);
   assign status.sweep_last    = cmd.sweep_all ? (cnt_ff == AW'(CELLS - 1))
                                               : (cnt_ff == AW'(COLUMNS - 1));

   // Execute the item: cursor, origin and sweep setup
   always_comb begin
      ccol_in = ccol_ff;
      crow_in = crow_ff;
      top_in  = top_ff;
      base_in = base_ff;
      cnt_in  = cmd.sweep_wr ? cnt_ff + AW'(1) : cnt_ff;
      if (cmd.sweep_start) begin
         cnt_in = '0;
      end
      if (cmd.exec) begin
         case (func_ff)
            tcce_pkg::FUNC_PUT: begin
               ccol_in = put_col;
               if (put_adv) begin
                  if (crow_ff == ROW_LAST) begin
                     // Scroll: old top row becomes the blank bottom row
                     top_in  = top_next;
                     base_in = AW'(top_ff) * COLS_A;
                  end else begin
                     crow_in = crow_ff + ROW_W'(1);
                  end
               end
            end
            tcce_pkg::FUNC_CLEAR: begin
               ccol_in = '0;
               crow_in = '0;
               top_in  = '0;
               base_in = '0;
            end
            tcce_pkg::FUNC_SETPOS: begin
               ccol_in = icol_ff;
               crow_in = irow_ff;
            end
            default: ;
         endcase
      end
   end

   // Logical to physical row through the rotating origin
   assign cur_prow_sum = {1'b0, crow_ff} + {1'b0, top_ff};
   assign cur_prow     = (cur_prow_sum >= (ROW_W + 1)'(ROWS))
                         ? ROW_W'(cur_prow_sum - (ROW_W + 1)'(ROWS)) : cur_prow_sum[ROW_W-1:0];
   assign rd_prow_sum  = {1'b0, irow_ff} + {1'b0, top_ff};
   assign rd_prow      = (rd_prow_sum >= (ROW_W + 1)'(ROWS))
                         ? ROW_W'(rd_prow_sum - (ROW_W + 1)'(ROWS)) : rd_prow_sum[ROW_W-1:0];
   assign cur_addr     = AW'(cur_prow) * COLS_A + AW'(ccol_ff);
   assign rd_addr      = AW'(rd_prow) * COLS_A + AW'(icol_ff);
   assign sweep_addr   = base_ff + cnt_ff;

   // Memory write: blanking sweep or printed character
   assign ram_we    = cmd.sweep_wr || (cmd.exec && (func_ff == tcce_pkg::FUNC_PUT) && put_write);
   assign ram_waddr = cmd.sweep_wr ? sweep_addr : cur_addr;
   assign ram_wdata = cmd.sweep_wr ? '0 : {colour_ff, ch_ff};

   tcce_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   assign ofs_full = OW'(crow_ff) * OW'(COLUMNS) + OW'(ccol_ff);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ccol_ff   <= '0;
         crow_ff   <= '0;
         top_ff    <= '0;
         base_ff   <= '0;
         cnt_ff    <= '0;
         colour_ff <= tcce_pkg::COLOUR_RESET;
      end else begin
         ccol_ff <= ccol_in;
         crow_ff <= crow_in;
         top_ff  <= top_in;
         base_ff <= base_in;
         cnt_ff  <= cnt_in;
         if (csr_valid) begin
            colour_ff <= csr_data;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         func_ff <= req_func;
         ch_ff   <= req_ch;
         icol_ff <= icol_in;
         irow_ff <= irow_in;
      end
      if (cmd.read_capture) begin
         rd_ff <= ram_rdata;
      end
      if (cmd.rsp_load) begin
         ofs_ff <= ofs_full[tcce_pkg::OFFSET_W-1:0];
         if (func_ff == tcce_pkg::FUNC_READ) begin
            rchar_ff   <= rd_ff[tcce_pkg::CHAR_W-1:0];
            rcolour_ff <= rd_ff[CELL_W-1:tcce_pkg::CHAR_W];
         end else begin
            rchar_ff   <= '0;
            rcolour_ff <= '0;
         end
      end
   end

   assign rsp_cursor_offset = ofs_ff;
   assign rsp_cell_char     = rchar_ff;
   assign rsp_cell_colour   = rcolour_ff;

endmodule

>>> design/text_console_char_engine.sv
// Text console character engine: a COLUMNS by ROWS grid of character/colour cells.
// Each request is executed and its result loaded into the response register; a read
// cell first waits for the memory read data, a scroll blanks one row and a clear the
// whole grid, one cell per cycle. The next request is taken only once the previous result
// is handed over, so a stalled receiver holds it off. Reset is synchronous; afterwards a
// clearing pass blanks all COLUMNS*ROWS cells (2000 at 80 by 25) while req_tready stays low.
module text_console_char_engine #(
   parameter int unsigned COLUMNS = 80,
   parameter int unsigned ROWS    = 25
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // func[1:0], ch[9:2], col[16:10], row[21:17], zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // cursor_offset[10:0], cell_char[18:11],
                                    // cell_colour[26:19], zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data     // text_colour
);

   tcce_pkg::ctl_cmd_type    cmd;
   tcce_pkg::ctl_status_type status;
   logic [tcce_pkg::OFFSET_W-1:0] rsp_cursor_offset;
   logic [tcce_pkg::CHAR_W-1:0]   rsp_cell_char;
   logic [tcce_pkg::COLOUR_W-1:0] rsp_cell_colour;

   // Colour register accepts a write every cycle
   assign csr_ready = 1'b1;

   tcce_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tcce_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_func          (req_tdata[1:0]),
      .req_ch            (req_tdata[9:2]),
      .req_col           (req_tdata[16:10]),
      .req_row           (req_tdata[21:17]),
      .csr_valid         (csr_valid),
      .csr_data          (csr_data),
      .rsp_cursor_offset (rsp_cursor_offset),
      .rsp_cell_char     (rsp_cell_char),
      .rsp_cell_colour   (rsp_cell_colour)
   );

   // Pack the response transaction
   assign rsp_tdata = {5'd0, rsp_cell_colour, rsp_cell_char, rsp_cursor_offset};

endmodule

>>> tb/testbench.sv
// Self-checking testbench for text_console_char_engine: stream requests in, check every
// response against a cycle-free model of the character grid, cursor and colour register.
// Depends on tcce_pkg (function codes, control characters) and the engine RTL only.
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned COLUMNS    = 80;
   localparam int unsigned ROWS       = 25;
   localparam int unsigned CELL_COUNT = COLUMNS * ROWS;

   // Longest quiet stretch allowed; it must exceed a full clear of COLUMNS*ROWS cells
   localparam int unsigned WATCHDOG_LIMIT   = 10000;
   localparam int unsigned LONG_HOLD_CYCLES = 400;
   localparam int unsigned END_WAIT_CYCLES  = CELL_COUNT + 100;
   localparam int unsigned RANDOM_ITEMS     = 2000;
   localparam int unsigned PHASE_ITEMS      = 250;
   localparam int unsigned QUIET_TAIL_ITEMS = 300;

   typedef struct packed {
      logic [10:0] cursor_offset;
      logic [7:0]  cell_char;
      logic [7:0]  cell_colour;
   } console_rsp_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // func[1:0], ch[9:2], col[16:10], row[21:17], zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // cursor_offset[10:0], cell_char[18:11],
                                   // cell_colour[26:19], zero
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data   = '0;   // text_colour

   // Model of the engine state
   logic [15:0] grid_model [0:CELL_COUNT-1];
   logic [6:0]  cursor_col_model;
   logic [4:0]  cursor_row_model;
   logic [7:0]  colour_model;

   console_rsp_type pending_rsp [$];
   int unsigned  error_count   = 0;
   int unsigned  quiet_cycles  = 0;
   bit           idle_enable   = 1'b1;
   bit           hold_armed    = 1'b0;
   bit           hold_seen     = 1'b0;
   int unsigned  hold_left     = 0;
   int unsigned  gap_left      = 0;

   text_console_char_engine #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // 12 ns clock
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Advance the console model by one request and return the response it produces
   function automatic console_rsp_type console_step(input logic [1:0] func,
                                                    input logic [7:0] ch,
                                                    input logic [6:0] col_in,
                                                    input logic [4:0] row_in);
      console_rsp_type rsp;
      int unsigned  col_c;
      int unsigned  row_c;
      int unsigned  cur_col;
      int unsigned  cur_row;
      int unsigned  idx;
      rsp     = '0;
      col_c   = (col_in > COLUMNS - 1) ? COLUMNS - 1 : col_in;
      row_c   = (row_in > ROWS - 1) ? ROWS - 1 : row_in;
      cur_col = cursor_col_model;
      cur_row = cursor_row_model;
      case (func)
         tcce_pkg::FUNC_PUT: begin
            if (ch == tcce_pkg::CHAR_NEWLINE) begin
               cur_col = 0;
               cur_row++;
            end else if (ch == tcce_pkg::CHAR_TAB) begin
               cur_col += tcce_pkg::TAB_STEP - (cur_col % tcce_pkg::TAB_STEP);
            end else begin
               grid_model[cur_col + cur_row * COLUMNS] = {colour_model, ch};
               cur_col++;
            end
            if (cur_col >= COLUMNS) begin
               cur_col = 0;
               cur_row++;
            end
            // Scroll up one row and blank the bottom row
            if (cur_row >= ROWS) begin
               for (int unsigned i = 0; i < CELL_COUNT - COLUMNS; i++)
                  grid_model[i] = grid_model[i + COLUMNS];
               for (int unsigned i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
                  grid_model[i] = '0;
               cur_row = ROWS - 1;
            end
         end
         tcce_pkg::FUNC_CLEAR: begin
            for (int unsigned i = 0; i < CELL_COUNT; i++)
               grid_model[i] = '0;
            cur_col = 0;
            cur_row = 0;
         end
         tcce_pkg::FUNC_SETPOS: begin
            cur_col = col_c;
            cur_row = row_c;
         end
         tcce_pkg::FUNC_READ: begin
            idx             = col_c + row_c * COLUMNS;
            rsp.cell_char   = grid_model[idx][7:0];
            rsp.cell_colour = grid_model[idx][15:8];
         end
         default: ;
      endcase
      cursor_col_model  = cur_col[6:0];
      cursor_row_model  = cur_row[4:0];
      rsp.cursor_offset = 11'(cur_col + cur_row * COLUMNS);
      return rsp;
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("ERROR at %0t ns: %s", $time, msg);
   endtask

   // Offer one request, wait for the transaction, queue its expected response
   task automatic send_console_request(input logic [1:0] func, input logic [7:0] ch,
                                       input logic [6:0] col, input logic [4:0] row);
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, row, col, ch, func};
      do @(posedge clock); while (!req_tready);
      pending_rsp.push_back(console_step(func, ch, col, row));
      @(negedge clock);
   endtask

   task automatic pause_sender(input int unsigned cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // Hold the request side until every queued response has arrived
   task automatic wait_for_responses();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending_rsp.size() != 0);
   endtask

   task automatic write_text_colour(input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      colour_model = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Corners of every field, each control character, wrap, scroll and clamping
   task automatic test_directed();
      send_console_request(tcce_pkg::FUNC_PUT, 8'h41, 7'd0, 5'd0);
      send_console_request(tcce_pkg::FUNC_PUT, 8'h00, 7'd127, 5'd31);
      send_console_request(tcce_pkg::FUNC_PUT, 8'hFF, 7'd0, 5'd0);
      send_console_request(tcce_pkg::FUNC_READ, 8'h00, 7'd0, 5'd0);
      send_console_request(tcce_pkg::FUNC_READ, 8'hFF, 7'd2, 5'd0);
      send_console_request(tcce_pkg::FUNC_PUT, tcce_pkg::CHAR_TAB, 7'd0, 5'd0);
      send_console_request(tcce_pkg::FUNC_PUT, tcce_pkg::CHAR_NEWLINE, 7'd0, 5'd0);
      send_console_request(tcce_pkg::FUNC_SETPOS, 8'h00, 7'd78, 5'd0);
      send_console_request(tcce_pkg::FUNC_PUT, tcce_pkg::CHAR_TAB, 7'd0, 5'd0);
      send_console_request(tcce_pkg::FUNC_SETPOS, 8'hFF, 7'd127, 5'd31);
      send_console_request(tcce_pkg::FUNC_PUT, 8'h5A, 7'd0, 5'd0);
      send_console_request(tcce_pkg::FUNC_READ, 8'h00, 7'd127, 5'd31);
      send_console_request(tcce_pkg::FUNC_READ, 8'h00, 7'd79, 5'd23);
      send_console_request(tcce_pkg::FUNC_SETPOS, 8'h00, 7'd5, 5'd24);
      send_console_request(tcce_pkg::FUNC_PUT, tcce_pkg::CHAR_NEWLINE, 7'd0, 5'd0);
      send_console_request(tcce_pkg::FUNC_READ, 8'h00, 7'd79, 5'd22);
      send_console_request(tcce_pkg::FUNC_SETPOS, 8'h00, 7'd76, 5'd24);
      send_console_request(tcce_pkg::FUNC_PUT, tcce_pkg::CHAR_TAB, 7'd0, 5'd0);
      send_console_request(tcce_pkg::FUNC_READ, 8'h00, 7'd127, 5'd0);
      send_console_request(tcce_pkg::FUNC_READ, 8'h00, 7'd0, 5'd31);
      send_console_request(tcce_pkg::FUNC_CLEAR, 8'hFF, 7'd127, 5'd31);
      send_console_request(tcce_pkg::FUNC_READ, 8'h00, 7'd79, 5'd21);
      send_console_request(tcce_pkg::FUNC_READ, 8'h00, 7'd0, 5'd0);
      wait_for_responses();
   endtask

   // Colour register at both extremes, checked through written cells
   task automatic test_colour_extremes();
      write_text_colour(8'h00);
      send_console_request(tcce_pkg::FUNC_PUT, 8'h63, 7'd0, 5'd0);
      send_console_request(tcce_pkg::FUNC_READ, 8'h00, 7'd0, 5'd0);
      wait_for_responses();
      write_text_colour(8'hFF);
      send_console_request(tcce_pkg::FUNC_PUT, 8'h64, 7'd0, 5'd0);
      send_console_request(tcce_pkg::FUNC_READ, 8'h00, 7'd1, 5'd0);
      send_console_request(tcce_pkg::FUNC_READ, 8'h00, 7'd0, 5'd0);
      wait_for_responses();
   endtask

   // Receiver stalls for a long stretch while requests keep coming
   task automatic test_backpressure();
      @(posedge clock);
      hold_armed = !hold_armed;
      @(negedge clock);
      for (int i = 0; i < 40; i++)
         send_console_request(tcce_pkg::FUNC_PUT, 8'($urandom_range(32, 126)), 7'd0, 5'd0);
      wait_for_responses();
   endtask

   // Random traffic in phases, one colour setting per phase, quiet tail at the end
   task automatic test_random();
      int unsigned pick;
      int unsigned phase;
      logic [1:0]  func;
      logic [7:0]  ch;
      logic [6:0]  col;
      logic [4:0]  row;
      phase = 0;
      for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % PHASE_ITEMS == 0) begin
            wait_for_responses();
            case (phase)
               0:       write_text_colour(8'h00);
               1:       write_text_colour(8'hFF);
               default: write_text_colour(8'($urandom_range(0, 255)));
            endcase
            phase++;
         end
         if (n == RANDOM_ITEMS - QUIET_TAIL_ITEMS)
            idle_enable = 1'b0;
         if (idle_enable && $urandom_range(0, 4) == 0)
            pause_sender($urandom_range(1, 13));
         pick = $urandom_range(0, 99);
         ch   = 8'($urandom_range(0, 255));
         col  = 7'($urandom_range(0, 127));
         row  = 5'($urandom_range(0, 31));
         if (pick < 62) begin
            func = tcce_pkg::FUNC_PUT;
            if (pick < 6)
               ch = tcce_pkg::CHAR_NEWLINE;
            else if (pick < 12)
               ch = tcce_pkg::CHAR_TAB;
         end else if (pick < 64) begin
            func = tcce_pkg::FUNC_CLEAR;
         end else if (pick < 78) begin
            func = tcce_pkg::FUNC_SETPOS;
            // Favor the bottom rows so scrolling happens often
            if (pick < 71)
               row = 5'($urandom_range(ROWS - 4, ROWS - 1));
         end else begin
            func = tcce_pkg::FUNC_READ;
            if (pick < 89) begin
               col = 7'($urandom_range(0, COLUMNS - 1));
               row = 5'($urandom_range(ROWS - 3, ROWS - 1));
            end
         end
         send_console_request(func, ch, col, row);
      end
      wait_for_responses();
   endtask

   // Receiver: random stall bursts, plus one long hold when armed
   always @(negedge clock) begin
      if (hold_armed != hold_seen) begin
         hold_seen  <= hold_armed;
         hold_left  <= LONG_HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (gap_left != 0) begin
         gap_left   <= gap_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 15) == 0) begin
         gap_left   <= $urandom_range(0, 12);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compare each response transaction with the oldest expectation
   always @(posedge clock) begin
      console_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch($sformatf("response with nothing expected, data 0x%08h",
                                      rsp_tdata));
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_tdata[10:0] !== want.cursor_offset)
               report_mismatch($sformatf("cursor_offset got %0d expected %0d",
                                         rsp_tdata[10:0], want.cursor_offset));
            if (rsp_tdata[18:11] !== want.cell_char)
               report_mismatch($sformatf("cell_char got 0x%02h expected 0x%02h",
                                         rsp_tdata[18:11], want.cell_char));
            if (rsp_tdata[26:19] !== want.cell_colour)
               report_mismatch($sformatf("cell_colour got 0x%02h expected 0x%02h",
                                         rsp_tdata[26:19], want.cell_colour));
         end
      end
   end

   // Watchdog: end the run when no transaction moves for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("ERROR at %0t ns: no transaction for %0d cycles", $time, quiet_cycles);
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      for (int unsigned i = 0; i < CELL_COUNT; i++)
         grid_model[i] = '0;
      cursor_col_model = '0;
      cursor_row_model = '0;
      colour_model     = tcce_pkg::COLOUR_RESET;
      reset            = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_colour_extremes();
      test_backpressure();
      test_random();

      // Let any stray response show up before the verdict
      repeat (END_WAIT_CYCLES) @(posedge clock);
      if (pending_rsp.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", pending_rsp.size()));
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
